// ===== hdl/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

	localparam int FIELD_W = 20;

	// Operation codes
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_REALLOC = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [FIELD_W-1:0] request_bytes;
		logic [FIELD_W-1:0] block_offset;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic [FIELD_W-1:0] payload_offset;
		logic [FIELD_W-1:0] copy_length;
	} rsp_t;

	// Microprogram addresses
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_FLOOP,
		S_FHIT,
		S_FMARK,
		S_RINIT,
		S_ALOOP,
		S_ATAKE,
		S_AAPPEND,
		S_AADD,
		S_RFREE,
		S_FAIL,
		S_DONE
	} step_t;

	// Branch conditions
	typedef enum logic [3:0] {
		C_ALWAYS,
		C_ACCEPT,
		C_DISPATCH,
		C_FIND,
		C_FIT,
		C_IS_FREE,
		C_IS_REALLOC,
		C_ROOM,
		C_OUT
	} cond_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_IDX,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		FW_NONE,
		FW_IDX_CLR,
		FW_FIDX_SET,
		FW_CNT_CLR
	} fw_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_FAIL,
		RES_FREE,
		RES_ALLOC
	} res_sel_t;

	typedef struct packed {
		cond_t    cond;
		step_t    tgt_a;
		step_t    tgt_b;
		logic     clr;
		logic     adv;
		logic     save;
		logic     wr_size;
		rd_sel_t  rd_sel;
		fw_sel_t  fw;
		res_sel_t res;
	} ucode_t;

	// Sequencer to datapath
	typedef struct packed {
		logic     take;
		logic     clr;
		logic     adv;
		logic     save;
		logic     wr_size;
		logic     out_load;
		rd_sel_t  rd_sel;
		fw_sel_t  fw;
		res_sel_t res;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic [1:0] op;
		logic       at_end;
		logic       find_hit;
		logic       fit_hit;
		logic       room;
		logic       out_free;
	} stat_t;

	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '{cond: C_ALWAYS, tgt_a: S_IDLE, tgt_b: S_IDLE, clr: 1'b0, adv: 1'b0,
			save: 1'b0, wr_size: 1'b0, rd_sel: RD_IDX, fw: FW_NONE, res: RES_NONE};
		unique case (s)
			S_IDLE: begin
				w.cond  = C_ACCEPT;
				w.tgt_a = S_DISP;
			end
			S_DISP: begin
				w.cond   = C_DISPATCH;
				w.tgt_a  = S_ALOOP;
				w.tgt_b  = S_FLOOP;
				w.clr    = 1'b1;
				w.rd_sel = RD_ZERO;
			end
			S_FLOOP: begin
				w.cond   = C_FIND;
				w.tgt_a  = S_FAIL;
				w.tgt_b  = S_FHIT;
				w.adv    = 1'b1;
				w.save   = 1'b1;
				w.rd_sel = RD_NEXT;
			end
			S_FHIT: begin
				w.cond  = C_IS_FREE;
				w.tgt_a = S_FMARK;
				w.tgt_b = S_RINIT;
			end
			S_FMARK: begin
				w.tgt_a = S_DONE;
				w.fw    = FW_FIDX_SET;
				w.res   = RES_FREE;
			end
			S_RINIT: begin
				w.tgt_a  = S_ALOOP;
				w.clr    = 1'b1;
				w.rd_sel = RD_ZERO;
			end
			S_ALOOP: begin
				w.cond   = C_FIT;
				w.tgt_a  = S_AAPPEND;
				w.tgt_b  = S_ATAKE;
				w.adv    = 1'b1;
				w.rd_sel = RD_NEXT;
			end
			S_ATAKE: begin
				w.cond  = C_IS_REALLOC;
				w.tgt_a = S_RFREE;
				w.tgt_b = S_DONE;
				w.fw    = FW_IDX_CLR;
				w.res   = RES_ALLOC;
			end
			S_AAPPEND: begin
				w.cond  = C_ROOM;
				w.tgt_a = S_AADD;
				w.tgt_b = S_FAIL;
			end
			S_AADD: begin
				w.cond    = C_IS_REALLOC;
				w.tgt_a   = S_RFREE;
				w.tgt_b   = S_DONE;
				w.wr_size = 1'b1;
				w.fw      = FW_CNT_CLR;
				w.res     = RES_ALLOC;
			end
			S_RFREE: begin
				w.tgt_a = S_DONE;
				w.fw    = FW_FIDX_SET;
			end
			S_FAIL: begin
				w.tgt_a = S_DONE;
				w.res   = RES_FAIL;
			end
			S_DONE: begin
				w.cond  = C_OUT;
				w.tgt_a = S_IDLE;
			end
			default: begin
				w.tgt_a = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ffba_ram.sv =====
`default_nettype none

module ffba_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/ffba_seq.sv =====
`default_nettype none

module ffba_seq import ffba_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	input  wire stat_t stat,
	output ctrl_t      ctrl,
	output logic       idle
);

	step_t  pc_q;
	step_t  pc_d;
	ucode_t uw;

	assign uw   = ucode_rom(pc_q);
	assign idle = (pc_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Next step
	always_comb begin
		pc_d = uw.tgt_a;
		unique case (uw.cond)
			C_ALWAYS: pc_d = uw.tgt_a;
			C_ACCEPT: pc_d = cmd_valid ? uw.tgt_a : pc_q;
			C_DISPATCH: begin
				priority if (stat.op == OP_ALLOC) begin
					pc_d = uw.tgt_a;
				end else if (stat.op == OP_FREE || stat.op == OP_REALLOC) begin
					pc_d = uw.tgt_b;
				end else begin
					pc_d = S_FAIL;
				end
			end
			C_FIND: begin
				priority if (stat.at_end) begin
					pc_d = uw.tgt_a;
				end else if (stat.find_hit) begin
					pc_d = uw.tgt_b;
				end else begin
					pc_d = pc_q;
				end
			end
			C_FIT: begin
				priority if (stat.at_end) begin
					pc_d = uw.tgt_a;
				end else if (stat.fit_hit) begin
					pc_d = uw.tgt_b;
				end else begin
					pc_d = pc_q;
				end
			end
			C_IS_FREE:    pc_d = (stat.op == OP_FREE) ? uw.tgt_a : uw.tgt_b;
			C_IS_REALLOC: pc_d = (stat.op == OP_REALLOC) ? uw.tgt_a : uw.tgt_b;
			C_ROOM:       pc_d = stat.room ? uw.tgt_a : uw.tgt_b;
			C_OUT:        pc_d = stat.out_free ? uw.tgt_a : pc_q;
			default:      pc_d = S_IDLE;
		endcase
	end

	// Datapath controls
	always_comb begin
		logic hit;
		hit           = (uw.cond == C_FIND) ? stat.find_hit : stat.fit_hit;
		ctrl.take     = (uw.cond == C_ACCEPT) && cmd_valid;
		ctrl.clr      = uw.clr;
		// advance only while the walk goes on; hold index and position on a hit
		ctrl.adv      = uw.adv && !stat.at_end && !hit;
		ctrl.save     = uw.save && !stat.at_end && stat.find_hit;
		ctrl.wr_size  = uw.wr_size;
		ctrl.out_load = (uw.cond == C_OUT) && stat.out_free;
		ctrl.rd_sel   = uw.rd_sel;
		ctrl.fw       = uw.fw;
		ctrl.res      = uw.res;
	end

endmodule

`default_nettype wire

// ===== hdl/ffba_dp.sv =====
`default_nettype none

module ffba_dp import ffba_pkg::*; #(
	parameter int POOL_BYTES   = 1048576,
	parameter int MAX_BLOCKS   = 1024,
	parameter int HEADER_BYTES = 5
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire ctrl_t ctrl,
	input  wire logic  res_stall,
	output stat_t      stat,
	output logic       res_valid,
	output rsp_t       res
);

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int AW = $clog2(MAX_BLOCKS);
	localparam logic [21:0]   HDR  = 22'(HEADER_BYTES);
	localparam logic [21:0]   POOL = 22'(POOL_BYTES);
	localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

	cmd_t               cmd_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      fidx_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_next;
	logic [20:0]        pos_q;
	logic [20:0]        end_q;
	logic [FIELD_W-1:0] prior_size_q;
	rsp_t               rslt_q;
	logic               res_valid_q;
	rsp_t               res_q;

	logic [FIELD_W-1:0] size_rd;
	logic [0:0]         free_rd;
	logic [AW-1:0]      rd_addr;
	logic               free_we;
	logic [AW-1:0]      free_waddr;
	logic [0:0]         free_wdata;

	logic [21:0]        pos_hdr;
	logic [21:0]        pos_step;
	logic [21:0]        end_add;
	logic [FIELD_W-1:0] copy_len;

	assign idx_next = idx_q + CW'(1);
	assign pos_hdr  = {1'b0, pos_q} + HDR;
	assign pos_step = pos_hdr + {2'b00, size_rd};
	assign end_add  = {1'b0, end_q} + HDR + {2'b00, cmd_q.request_bytes};
	assign copy_len = (prior_size_q < cmd_q.request_bytes) ? prior_size_q
		: cmd_q.request_bytes;

	always_comb begin
		unique case (ctrl.rd_sel)
			RD_ZERO: rd_addr = '0;
			RD_IDX:  rd_addr = idx_q[AW-1:0];
			RD_NEXT: rd_addr = idx_next[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		free_we    = 1'b0;
		free_waddr = idx_q[AW-1:0];
		free_wdata = 1'b0;
		unique case (ctrl.fw)
			FW_NONE: free_we = 1'b0;
			FW_IDX_CLR: begin
				free_we    = 1'b1;
				free_waddr = idx_q[AW-1:0];
				free_wdata = 1'b0;
			end
			FW_FIDX_SET: begin
				free_we    = 1'b1;
				free_waddr = fidx_q[AW-1:0];
				free_wdata = 1'b1;
			end
			FW_CNT_CLR: begin
				free_we    = 1'b1;
				free_waddr = count_q[AW-1:0];
				free_wdata = 1'b0;
			end
			default: free_we = 1'b0;
		endcase
	end

	ffba_ram #(
		.WIDTH(FIELD_W),
		.DEPTH(MAX_BLOCKS)
	) u_size_ram (
		.clk  (clk),
		.we   (ctrl.wr_size),
		.waddr(count_q[AW-1:0]),
		.wdata(cmd_q.request_bytes),
		.raddr(rd_addr),
		.rdata(size_rd)
	);

	ffba_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLOCKS)
	) u_free_ram (
		.clk  (clk),
		.we   (free_we),
		.waddr(free_waddr),
		.wdata(free_wdata),
		.raddr(rd_addr),
		.rdata(free_rd)
	);

	always_comb begin
		stat.op       = cmd_q.operation;
		stat.at_end   = (idx_q == count_q);
		stat.find_hit = (pos_hdr == {2'b00, cmd_q.block_offset});
		stat.fit_hit  = free_rd[0] && (size_rd >= cmd_q.request_bytes);
		stat.room     = (count_q < MAXB) && (end_add < POOL);
		stat.out_free = !res_valid_q || !res_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			end_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				idx_q <= '0;
				pos_q <= '0;
			end else if (ctrl.adv) begin
				idx_q <= idx_next;
				pos_q <= pos_step[20:0];
			end
			if (ctrl.wr_size) begin
				count_q <= count_q + CW'(1);
				end_q   <= end_add[20:0];
			end
			if (ctrl.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			cmd_q <= cmd;
		end
		if (ctrl.save) begin
			fidx_q       <= idx_q;
			prior_size_q <= size_rd;
		end
		unique case (ctrl.res)
			RES_NONE: rslt_q <= rslt_q;
			RES_FAIL: rslt_q <= '0;
			RES_FREE: rslt_q <= '{ok: 1'b1, payload_offset: '0, copy_length: '0};
			RES_ALLOC: begin
				rslt_q.ok             <= 1'b1;
				rslt_q.payload_offset <= pos_hdr[FIELD_W-1:0];
				rslt_q.copy_length    <= (cmd_q.operation == OP_REALLOC) ? copy_len : '0;
			end
			default: rslt_q <= rslt_q;
		endcase
		if (ctrl.out_load) begin
			res_q <= rslt_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== hdl/first_fit_block_allocator.sv =====
`default_nettype none

// First-fit allocator over a byte pool. Each command (allocate, free,
// reallocate) gives one result. Blocks lie back to back, each a header
// followed by its payload; the block table walks one entry per cycle through
// the read port of its size and free memories. A free finds the block by its
// offset; a reallocate finds it, then allocates. One command is in work at a
// time; the next command transfers once the previous result sits in the
// output register, even while that result is stalled.
// The tables need no clearing after reset: only entries below the block count
// are ever used.
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int POOL_BYTES   = 1048576,
	parameter int MAX_BLOCKS   = 1024,
	parameter int HEADER_BYTES = 5
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output rsp_t      res
);

	ctrl_t ctrl;
	stat_t stat;
	logic  idle;

	assign cmd_stall = !idle;

	ffba_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.idle     (idle)
	);

	ffba_dp #(
		.POOL_BYTES  (POOL_BYTES),
		.MAX_BLOCKS  (MAX_BLOCKS),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.ctrl     (ctrl),
		.res_stall(res_stall),
		.stat     (stat),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule

`default_nettype wire

// ===== hdl/ffba_checker.sv =====
`default_nettype none

module ffba_checker import ffba_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_stall,
	input wire cmd_t cmd,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire rsp_t res
);

	// One command in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command transferred while another is in work");

	// A fresh result never shows up in the cycle right after a transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> !$rose(res_valid))
		else $error("result appeared too early after a command");

	// A failed result carries no offset and no copy length
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.ok) |-> (res.payload_offset == '0 && res.copy_length == '0))
		else $error("failed result with nonzero fields");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result dropped or changed");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

`default_nettype wire
